/* src/esh_pkg.sv */
package esh_pkg;

  localparam int MAX_SEQ_BYTES = 8;
  localparam int LEN_W = 4;
  localparam int IDX_W = 3;
  localparam int PERIOD_W = 16;
  localparam int SEQ_W = 8 * MAX_SEQ_BYTES;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 16;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_RX = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_ESCAPE_BYTES = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ESCAPE_LENGTH = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_REPLY_BYTES = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_REPLY_LENGTH = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_PERIOD_TICKS = 3'd4;

  localparam logic [SEQ_W-1:0] RST_ESCAPE_BYTES = 64'h0000_0000_337A_7E74;
  localparam logic [LEN_W-1:0] RST_ESCAPE_LENGTH = 4'd4;
  localparam logic [SEQ_W-1:0] RST_REPLY_BYTES = 64'd20;
  localparam logic [LEN_W-1:0] RST_REPLY_LENGTH = 4'd1;
  localparam logic [PERIOD_W-1:0] RST_PERIOD_TICKS = 16'd100;

  typedef struct packed {
    logic [SEQ_W-1:0] escape_bytes;
    logic [LEN_W-1:0] escape_len;
    logic [SEQ_W-1:0] reply_bytes;
    logic [LEN_W-1:0] reply_len;
    logic [PERIOD_W-1:0] period;
  } esh_cfg_t;

  typedef struct packed {
    logic go;
    logic fin;
    logic [LEN_W-1:0] len;
  } esh_burst_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    clamp_len = (len > LEN_W'(MAX_SEQ_BYTES)) ? LEN_W'(MAX_SEQ_BYTES) : len;
  endfunction

endpackage

/* src/esh_cfg.sv */
module esh_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [esh_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [esh_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output esh_pkg::esh_cfg_t                   cfg
);
  import esh_pkg::*;

  logic [SEQ_W-1:0]    escape_bytes_r;
  logic [LEN_W-1:0]    escape_length_r;
  logic [SEQ_W-1:0]    reply_bytes_r;
  logic [LEN_W-1:0]    reply_length_r;
  logic [PERIOD_W-1:0] period_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_bytes_r  <= RST_ESCAPE_BYTES;
      escape_length_r <= RST_ESCAPE_LENGTH;
      reply_bytes_r   <= RST_REPLY_BYTES;
      reply_length_r  <= RST_REPLY_LENGTH;
      period_ticks_r  <= RST_PERIOD_TICKS;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ESCAPE_BYTES:  escape_bytes_r  <= cfg_wdata[SEQ_W-1:0];
        REG_ESCAPE_LENGTH: escape_length_r <= cfg_wdata[LEN_W-1:0];
        REG_REPLY_BYTES:   reply_bytes_r   <= cfg_wdata[SEQ_W-1:0];
        REG_REPLY_LENGTH:  reply_length_r  <= cfg_wdata[LEN_W-1:0];
        REG_PERIOD_TICKS:  period_ticks_r  <= cfg_wdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Lengths saturate at the sequence size and a zero period counts as one tick.
  always_comb begin
    cfg.escape_bytes = escape_bytes_r;
    cfg.escape_len   = clamp_len(escape_length_r);
    cfg.reply_bytes  = reply_bytes_r;
    cfg.reply_len    = clamp_len(reply_length_r);
    cfg.period       = (period_ticks_r == '0) ? PERIOD_W'(1) : period_ticks_r;
  end

endmodule

/* src/esh_ctl.sv */
module esh_ctl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  esh_pkg::esh_cfg_t    cfg,
  input  logic                 accept,
  input  logic [1:0]           cmd,
  input  logic [7:0]           rx_byte,
  output esh_pkg::esh_burst_t  burst
);
  import esh_pkg::*;

  logic [LEN_W-1:0]    mi_r, mi_nxt;
  logic                ma_r, ma_nxt;
  logic                running_r, running_nxt;
  logic [PERIOD_W-1:0] wait_r, wait_nxt;

  logic [LEN_W-1:0]    so_mi;
  logic                so_ma;
  logic                do_so;
  logic [PERIOD_W-1:0] wait_dec;
  logic [7:0]          want;

  assign want = cfg.reply_bytes[8*mi_r[IDX_W-1:0] +: 8];
  assign wait_dec = (wait_r != '0) ? wait_r - PERIOD_W'(1) : wait_r;

  always_comb begin
    mi_nxt      = mi_r;
    ma_nxt      = ma_r;
    running_nxt = running_r;
    wait_nxt    = wait_r;
    so_mi       = mi_r;
    so_ma       = ma_r;
    do_so       = 1'b0;
    burst       = '0;
    if (accept) begin
      case (cmd)
        CMD_START: begin
          mi_nxt = '0;
          ma_nxt = 1'b1;
          so_mi  = '0;
          so_ma  = 1'b1;
          do_so  = 1'b1;
        end
        CMD_RX: begin
          if (running_r && ma_r && (mi_r < cfg.reply_len)) begin
            if (want == rx_byte) begin
              mi_nxt = mi_r + LEN_W'(1);
            end else begin
              ma_nxt = 1'b0;
            end
          end
        end
        CMD_TICK: begin
          if (running_r) begin
            if (wait_dec == '0) begin
              do_so = 1'b1;
            end else begin
              wait_nxt = wait_dec;
            end
          end
        end
        default: ;
      endcase
      // On a start or at the end of a period a full match finishes, anything else sends the escape burst.
      if (do_so) begin
        if (so_ma && (so_mi == cfg.reply_len)) begin
          running_nxt = 1'b0;
          wait_nxt    = '0;
          burst.go    = 1'b1;
          burst.fin   = 1'b1;
        end else begin
          mi_nxt      = '0;
          ma_nxt      = 1'b1;
          running_nxt = 1'b1;
          wait_nxt    = cfg.period;
          burst.go    = (cfg.escape_len != '0);
          burst.len   = cfg.escape_len;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mi_r      <= '0;
      ma_r      <= 1'b1;
      running_r <= 1'b0;
      wait_r    <= '0;
    end else begin
      mi_r      <= mi_nxt;
      ma_r      <= ma_nxt;
      running_r <= running_nxt;
      wait_r    <= wait_nxt;
    end
  end

  a_run_wait: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> (wait_r != '0))
    else $error("Running handshake with an expired period counter.");

  a_idle_wait: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> (wait_r == '0))
    else $error("Idle handshake with a live period counter.");

  a_mi_range: assert property (@(posedge clk) disable iff (!rst_n)
    mi_r <= LEN_W'(MAX_SEQ_BYTES))
    else $error("Match index beyond the reply length limit.");

endmodule

/* src/esh_emit.sv */
module esh_emit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  esh_pkg::esh_burst_t               burst,
  input  logic [esh_pkg::SEQ_W-1:0]         escape_bytes,
  output logic                              free,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [esh_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tlast
);
  import esh_pkg::*;

  logic             busy_r, busy_nxt;
  logic             fin_r, fin_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [SEQ_W-1:0] bytes_r, bytes_nxt;
  logic             last;
  logic             beat;

  assign last = fin_r || (rem_r == LEN_W'(1));
  assign beat = busy_r && out_tready;
  assign free = !busy_r || (out_tready && last);

  always_comb begin
    busy_nxt  = busy_r;
    fin_nxt   = fin_r;
    rem_nxt   = rem_r;
    bytes_nxt = bytes_r;
    if (beat) begin
      rem_nxt   = rem_r - LEN_W'(1);
      bytes_nxt = bytes_r >> 8;
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
    if (load && burst.go) begin
      busy_nxt  = 1'b1;
      fin_nxt   = burst.fin;
      rem_nxt   = burst.fin ? LEN_W'(1) : burst.len;
      bytes_nxt = escape_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      rem_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      rem_r  <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
  end

  assign out_tvalid = busy_r;
  assign out_tlast  = last;
  assign out_tdata  = {(OUT_DATA_W-10)'(0), fin_r, !fin_r,
                       fin_r ? 8'h00 : bytes_r[7:0]};

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (load && burst.go) |-> free)
    else $error("New burst loaded over one still in flight.");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !fin_r) |-> ((rem_r != '0) && (rem_r <= LEN_W'(MAX_SEQ_BYTES))))
    else $error("Burst byte count out of range.");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (beat && last && !load) |=> !busy_r)
    else $error("Burst continued past its last transaction.");

endmodule

/* src/escape_sequence_handshake_core.sv */
// Channel | Direction | tdata bits (low to high)             | tlast | tuser
// in_     | slave     | cmd[1:0], rx_byte[9:2]                | -     | -
// out_    | master    | tx_byte[7:0], tx_valid[8], finished[9] | last  | -
// cfg_    | write     | index 0..4, data up to 64 bits         | -     | -
// An input transaction is processed in the cycle it is accepted; a start or a
// period end loads a burst of up to eight results, one per cycle unless stalled.
// Input is accepted whenever the result register is empty or is giving up its
// last transaction in the same cycle, so a new burst can follow without a gap.
// Results are stalled by out_tready; the inputs then wait behind the burst.
// Reset is synchronous on rst_n and restores the register defaults.
module escape_sequence_handshake_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [esh_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [esh_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [esh_pkg::IN_DATA_W-1:0]     in_tdata,   // cmd, rx_byte
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [esh_pkg::OUT_DATA_W-1:0]    out_tdata,  // tx_byte, tx_valid, finished
  output logic                              out_tlast
);
  import esh_pkg::*;

  esh_cfg_t   cfg;
  esh_burst_t burst;
  logic       free;
  logic       accept;

  assign in_tready = free;
  assign accept    = in_tvalid && in_tready;

  esh_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  esh_ctl u_ctl (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .accept  (accept),
    .cmd     (in_tdata[1:0]),
    .rx_byte (in_tdata[9:2]),
    .burst   (burst)
  );

  esh_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (accept),
    .burst        (burst),
    .escape_bytes (cfg.escape_bytes),
    .free         (free),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast)
  );

endmodule
